// ===== rtl/cbg_pkg.sv =====
// shared widths, codes and types for the bar graph code generator
`timescale 1ns / 1ps

package cbg_pkg;

	localparam int PROG_W     = 16;
	localparam int LEN_W      = 6;
	localparam int CODE_W     = 3;
	// progress * cells * 6 never exceeds 25 bits for 16-bit progress and 6-bit length
	localparam int MUL_W      = 9;
	localparam int PROD_W     = PROG_W + MUL_W;
	localparam int MUL_STEPS  = MUL_W;
	localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
	localparam int DIV_STEPS  = PROD_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	// pixel count saturates here, well past the longest bar
	localparam int PIX_W      = 10;
	localparam int DIFF_W     = PIX_W + 1;

	localparam logic [CODE_W-1:0] FULL_CODE  = 3'd5;
	localparam logic [CODE_W-1:0] EMPTY_CODE = 3'd0;
	localparam logic signed [DIFF_W-1:0] PIX_PER_CELL = 11'sd6;
	localparam logic signed [DIFF_W-1:0] FULL_MIN     = 11'sd5;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  index;
		logic              last;
	} cell_t;

endpackage

// ===== rtl/cbg_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module cbg_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [cbg_pkg::PROG_W-1:0]   mcand,
	input  logic [cbg_pkg::MUL_W-1:0]    mplier,
	output logic                         done,
	output logic [cbg_pkg::PROD_W-1:0]   product
);

	logic                           busy_q;
	logic                           done_q;
	logic [cbg_pkg::MUL_CNT_W-1:0]  cnt_q;
	logic [cbg_pkg::PROD_W-1:0]     acc_q;
	logic [cbg_pkg::PROD_W-1:0]     mcand_q;
	logic [cbg_pkg::MUL_W-1:0]      mplier_q;
	logic                           last_step;

	assign last_step = (cnt_q == cbg_pkg::MUL_CNT_W'(cbg_pkg::MUL_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= cbg_pkg::PROD_W'(mcand);
			mplier_q <= mplier;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[cbg_pkg::PROD_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[cbg_pkg::MUL_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== rtl/cbg_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module cbg_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [cbg_pkg::PROD_W-1:0]   dividend,
	input  logic [cbg_pkg::PROG_W-1:0]   divisor,
	output logic                         done,
	output logic [cbg_pkg::PROD_W-1:0]   quotient
);

	logic                           busy_q;
	logic                           done_q;
	logic [cbg_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [cbg_pkg::PROD_W-1:0]     dvd_q;
	logic [cbg_pkg::PROG_W-1:0]     rem_q;
	logic [cbg_pkg::PROG_W-1:0]     dvs_q;
	logic [cbg_pkg::PROG_W:0]       shifted;
	logic [cbg_pkg::PROG_W+1:0]     diff;
	logic                           ge;
	logic                           last_step;

	assign last_step = (cnt_q == cbg_pkg::DIV_CNT_W'(cbg_pkg::DIV_STEPS - 1));
	assign shifted   = {rem_q, dvd_q[cbg_pkg::PROD_W-1]};
	assign diff      = {1'b0, shifted} - {2'b00, dvs_q};
	// a zero divisor sets every quotient bit, which later saturates to a full bar
	assign ge        = !diff[cbg_pkg::PROG_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[cbg_pkg::PROG_W-1:0] : shifted[cbg_pkg::PROG_W-1:0];
			dvd_q <= {dvd_q[cbg_pkg::PROD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ===== rtl/cbg_emit.sv =====
// walks the cells of the bar and drives the output register, one cell per transaction
`timescale 1ns / 1ps

module cbg_emit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [cbg_pkg::PROD_W-1:0]   pix,
	input  logic [cbg_pkg::LEN_W-1:0]    len,
	output logic                         done,
	output logic                         out_valid,
	input  logic                         out_stall,
	output cbg_pkg::cell_t               cell_data
);

	logic                                busy_q;
	logic                                out_valid_q;
	cbg_pkg::cell_t                      cell_q;
	logic signed [cbg_pkg::DIFF_W-1:0]   d_q;
	logic [cbg_pkg::LEN_W-1:0]           k_q;
	logic [cbg_pkg::LEN_W-1:0]           len_q;
	logic [cbg_pkg::PIX_W-1:0]           pix_sat;
	logic                                load;
	logic                                is_last;
	logic [cbg_pkg::CODE_W-1:0]          code;

	assign pix_sat = (pix[cbg_pkg::PROD_W-1:cbg_pkg::PIX_W] != '0) ? '1
		: pix[cbg_pkg::PIX_W-1:0];

	assign load    = busy_q && (!out_valid_q || !out_stall);
	assign is_last = (k_q == cbg_pkg::LEN_W'(len_q - 1'b1));
	// zero-length bar finishes at once
	assign done    = (start && (len == '0)) || (load && is_last);

	// d_q is the pixel count minus the first pixel of the current cell
	always_comb begin
		priority if (d_q[cbg_pkg::DIFF_W-1]) begin
			code = cbg_pkg::EMPTY_CODE;
		end else if (d_q >= cbg_pkg::FULL_MIN) begin
			code = cbg_pkg::FULL_CODE;
		end else begin
			code = d_q[cbg_pkg::CODE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start && (len != '0)) begin
				busy_q <= 1'b1;
			end else if (load && is_last) begin
				busy_q <= 1'b0;
			end
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= load;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= cbg_pkg::DIFF_W'({1'b0, pix_sat});
			k_q   <= '0;
			len_q <= len;
		end else if (load) begin
			d_q <= d_q - cbg_pkg::PIX_PER_CELL;
			k_q <= k_q + 1'b1;
		end
		if (load) begin
			cell_q.code  <= code;
			cell_q.index <= k_q;
			cell_q.last  <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign cell_data = cell_q;

endmodule

// ===== rtl/char_lcd_bar_graph_codes.sv =====
// top level: character lcd bar graph glyph code generator
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  request | in_valid, in_stall, progress, progress_max,  | in
//          | bar_length                                   |
//  cells   | out_valid, out_stall, cell_code, cell_index, | out
//          | last_cell                                    |
//
// a request passes through the serial multiplier, then the restoring divider,
// then the cell walk, which gives one cell per cycle while out_stall is low.
// a new request is taken once the last cell of the previous one sits in the
// output register, even while that cell is still stalled.
// reset clears the sequencer and the output valid; no clearing pass is needed.
// out_stall holds the current cell and pauses the cell walk.
`timescale 1ns / 1ps

module char_lcd_bar_graph_codes #(
	parameter int MAX_CELLS = 40
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cbg_pkg::PROG_W-1:0]    progress,
	input  logic [cbg_pkg::PROG_W-1:0]    progress_max,
	input  logic [cbg_pkg::LEN_W-1:0]     bar_length,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cbg_pkg::CODE_W-1:0]    cell_code,
	output logic [cbg_pkg::LEN_W-1:0]     cell_index,
	output logic                          last_cell
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_EMIT
	} state_t;

	localparam logic [cbg_pkg::LEN_W:0] MAX_LEN = (cbg_pkg::LEN_W + 1)'(MAX_CELLS);

	state_t                          state_q;
	logic                            in_stall_q;
	logic [cbg_pkg::PROG_W-1:0]      pmax_q;
	logic [cbg_pkg::LEN_W-1:0]       len_q;
	logic                            accept;
	logic [cbg_pkg::LEN_W-1:0]       len_sat;
	logic [cbg_pkg::MUL_W-1:0]       len_x6;
	logic                            mul_done;
	logic [cbg_pkg::PROD_W-1:0]      product;
	logic                            div_done;
	logic [cbg_pkg::PROD_W-1:0]      quotient;
	logic                            emit_done;
	cbg_pkg::cell_t                  cell_data;

	assign accept  = in_valid && !in_stall_q;
	assign len_sat = ({1'b0, bar_length} > MAX_LEN) ? MAX_LEN[cbg_pkg::LEN_W-1:0] : bar_length;
	assign len_x6  = (cbg_pkg::MUL_W'(len_sat) << 2) + (cbg_pkg::MUL_W'(len_sat) << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q    <= S_MUL;
						in_stall_q <= 1'b1;
					end
				end
				S_MUL: begin
					if (mul_done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// an empty bar is finished as soon as the divide is
					if (div_done && emit_done) begin
						state_q    <= S_IDLE;
						in_stall_q <= 1'b0;
					end else if (div_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_done) begin
						state_q    <= S_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_stall_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pmax_q <= progress_max;
			len_q  <= len_sat;
		end
	end

	cbg_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.mcand   (progress),
		.mplier  (len_x6),
		.done    (mul_done),
		.product (product)
	);

	cbg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mul_done),
		.dividend (product),
		.divisor  (pmax_q),
		.done     (div_done),
		.quotient (quotient)
	);

	cbg_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_done),
		.pix       (quotient),
		.len       (len_q),
		.done      (emit_done),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cell_data (cell_data)
	);

	assign in_stall   = in_stall_q;
	assign cell_code  = cell_data.code;
	assign cell_index = cell_data.index;
	assign last_cell  = cell_data.last;

`ifndef SYNTHESIS
	// more cells pending means the sequencer is still walking the bar
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_cell) |-> (state_q == S_EMIT))
		else $error("cell transaction without last flag while not emitting");

	assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MUL))
		else $error("multiplier finished outside its phase");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside its phase");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cell_code <= cbg_pkg::FULL_CODE))
		else $error("glyph code out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_cell) |=> (cell_index != '0 || !out_valid))
		else $error("cell index restarted inside a bar");
`endif

endmodule

// ===== bench/cbg_checker.sv =====
// checker for the bar graph code generator: predicts every cell of a request and compares
`timescale 1ns / 1ps

module cbg_checker #(
	parameter int MAX_CELLS = 40
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [cbg_pkg::PROG_W-1:0] progress,
	input  logic [cbg_pkg::PROG_W-1:0] progress_max,
	input  logic [cbg_pkg::LEN_W-1:0]  bar_length,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [cbg_pkg::CODE_W-1:0] cell_code,
	input  logic [cbg_pkg::LEN_W-1:0]  cell_index,
	input  logic                       last_cell,
	output int                         fail_count,
	output int                         pending,
	output int                         cells_checked
);

	localparam longint unsigned CELL_PIXELS = 6;

	cbg_pkg::cell_t cells_due[$];

	function automatic logic [cbg_pkg::CODE_W-1:0] glyph_for(longint unsigned pix,
			longint unsigned idx, bit all_full);
		longint unsigned first_pix;
		first_pix = idx * CELL_PIXELS;
		if (all_full || first_pix + 5 <= pix)
			return cbg_pkg::FULL_CODE;
		if (first_pix > pix)
			return cbg_pkg::EMPTY_CODE;
		// partial cell, including a fill point right on the cell boundary
		return cbg_pkg::CODE_W'(pix % CELL_PIXELS);
	endfunction

	function automatic void predict_bar(logic [cbg_pkg::PROG_W-1:0] prog,
			logic [cbg_pkg::PROG_W-1:0] pmax, logic [cbg_pkg::LEN_W-1:0] len);
		longint unsigned cells;
		longint unsigned pix;
		longint unsigned wide_prog;
		longint unsigned wide_max;
		cbg_pkg::cell_t c;
		cells = (len > MAX_CELLS) ? MAX_CELLS : len;
		wide_prog = prog;
		wide_max = pmax;
		pix = 0;
		if (pmax != 0)
			pix = (wide_prog * cells * CELL_PIXELS) / wide_max;
		for (longint unsigned k = 0; k < cells; k++) begin
			c.code = glyph_for(pix, k, pmax == 0);
			c.index = cbg_pkg::LEN_W'(k);
			c.last = (k + 1 == cells);
			cells_due.push_back(c);
		end
	endfunction

	always @(posedge clk) begin
		cbg_pkg::cell_t want;
		int errs;
		errs = 0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (cells_due.size() == 0) begin
					errs++;
					$display("%0t: unexpected cell, expected none, got code %0d index %0d last %0b",
						$time, cell_code, cell_index, last_cell);
				end else begin
					want = cells_due.pop_front();
					if (cell_code !== want.code) begin
						errs++;
						$display("%0t: cell_code mismatch, expected %0d, got %0d",
							$time, want.code, cell_code);
					end
					if (cell_index !== want.index) begin
						errs++;
						$display("%0t: cell_index mismatch, expected %0d, got %0d",
							$time, want.index, cell_index);
					end
					if (last_cell !== want.last) begin
						errs++;
						$display("%0t: last_cell mismatch, expected %0b, got %0b",
							$time, want.last, last_cell);
					end
				end
				cells_checked <= cells_checked + 1;
			end
			if (in_valid && !in_stall)
				predict_bar(progress, progress_max, bar_length);
		end
		fail_count <= fail_count + errs;
		pending <= cells_due.size();
	end

endmodule

// ===== bench/char_lcd_bar_graph_codes_tb.sv =====
// testbench top for the bar graph code generator: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps

module char_lcd_bar_graph_codes_tb;

	localparam int MAX_CELLS     = 40;
	localparam int DIRECTED      = 24;
	localparam int RANDOM_ITEMS  = 180;
	localparam int HOLD_AT       = 200;
	localparam int HOLD_CYCLES   = 400;
	localparam int IDLE_LIMIT    = 4000;
	localparam int DRAIN_CYCLES  = 200;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [cbg_pkg::PROG_W-1:0] progress;
	logic [cbg_pkg::PROG_W-1:0] progress_max;
	logic [cbg_pkg::LEN_W-1:0]  bar_length;
	logic                       out_valid;
	logic                       out_stall;
	logic [cbg_pkg::CODE_W-1:0] cell_code;
	logic [cbg_pkg::LEN_W-1:0]  cell_index;
	logic                       last_cell;

	int fail_count;
	int pending;
	int cells_checked;
	int items_sent;
	int rx_cells;

	char_lcd_bar_graph_codes #(
		.MAX_CELLS(MAX_CELLS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.progress    (progress),
		.progress_max(progress_max),
		.bar_length  (bar_length),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cell_code   (cell_code),
		.cell_index  (cell_index),
		.last_cell   (last_cell)
	);

	cbg_checker #(
		.MAX_CELLS(MAX_CELLS)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.progress     (progress),
		.progress_max (progress_max),
		.bar_length   (bar_length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cell_code    (cell_code),
		.cell_index   (cell_index),
		.last_cell    (last_cell),
		.fail_count   (fail_count),
		.pending      (pending),
		.cells_checked(cells_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one request transaction; a zero gap keeps valid high into the next one
	task automatic send_request(input logic [cbg_pkg::PROG_W-1:0] prog,
			input logic [cbg_pkg::PROG_W-1:0] pmax, input logic [cbg_pkg::LEN_W-1:0] len);
		int gap;
		gap = (items_sent % 40 < 10) ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		progress <= prog;
		progress_max <= pmax;
		bar_length <= len;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	initial begin
		int pick;
		int len;
		int pmax;
		int prog;
		int step_size;
		in_valid <= 1'b0;
		progress <= '0;
		progress_max <= '0;
		bar_length <= '0;
		arst_n <= 1'b0;
		items_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_request(16'd0, 16'd100, 6'd10);
		send_request(16'd100, 16'd100, 6'd10);
		send_request(16'd50, 16'd100, 6'd10);
		send_request(16'd0, 16'd0, 6'd5);
		send_request(16'hFFFF, 16'd0, 6'd40);
		send_request(16'hFFFF, 16'hFFFF, 6'd40);
		send_request(16'hFFFF, 16'd1, 6'd40);
		send_request(16'd200, 16'd100, 6'd8);
		send_request(16'd1, 16'hFFFF, 6'd40);
		send_request(16'd1, 16'd2, 6'd4);
		send_request(16'd0, 16'd5, 6'd0);
		send_request(16'd7, 16'd9, 6'd0);
		send_request(16'd10, 16'd20, 6'd63);
		send_request(16'd12345, 16'd54321, 6'd41);
		send_request(16'd30000, 16'd60000, 6'd32);
		send_request(16'd1, 16'd1, 6'd1);
		send_request(16'd0, 16'd1, 6'd1);
		send_request(16'hFFFF, 16'hFFFE, 6'd39);
		send_request(16'd1, 16'd6, 6'd1);
		send_request(16'd2, 16'd6, 6'd1);
		send_request(16'd3, 16'd6, 6'd1);
		send_request(16'd4, 16'd6, 6'd1);
		send_request(16'd5, 16'd6, 6'd1);
		send_request(16'h8000, 16'h7FFF, 6'd21);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// mostly short bars keep the run quick; a few long and saturated ones
			pick = $urandom_range(0, 19);
			if (pick < 12)
				len = $urandom_range(1, 8);
			else if (pick < 17)
				len = $urandom_range(9, 40);
			else if (pick < 19)
				len = $urandom_range(41, 63);
			else
				len = 0;
			pick = $urandom_range(0, 9);
			if (pick == 0)
				pmax = 0;
			else if (pick < 4)
				pmax = $urandom_range(1, 20);
			else
				pmax = $urandom_range(0, 65535);
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				prog = $urandom_range(0, pmax);
			end else if (pick == 6) begin
				prog = $urandom_range(0, 65535);
			end else if (pick == 7) begin
				prog = (pmax + $urandom_range(1, 50)) & 16'hFFFF;
			end else if (len >= 1 && len <= MAX_CELLS) begin
				// fill point lands exactly on a cell boundary
				step_size = $urandom_range(1, 65535 / len);
				pmax = len * step_size;
				prog = $urandom_range(0, len) * step_size;
			end else begin
				prog = $urandom_range(0, pmax);
			end
			send_request(cbg_pkg::PROG_W'(prog), cbg_pkg::PROG_W'(pmax),
				cbg_pkg::LEN_W'(len));
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests (%0d directed) and %0d checked cells", items_sent, DIRECTED,
			cells_checked);
		$display("zero maximum, overrange progress, cell boundaries, zero and saturated lengths,"
			, " %0d-cycle output hold-off", HOLD_CYCLES);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// cell receiver: random stall before each cell, quiet stretches, one long hold-off
	initial begin
		int wait_cycles;
		bit held;
		out_stall <= 1'b0;
		held = 1'b0;
		rx_cells = 0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held && rx_cells >= HOLD_AT) begin
				held = 1'b1;
				wait_cycles = HOLD_CYCLES;
			end else if ((rx_cells / 64) % 4 == 1) begin
				wait_cycles = 0;
			end else begin
				wait_cycles = $urandom_range(0, 12);
			end
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			rx_cells++;
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/cbg_pkg.sv
rtl/cbg_mul.sv
rtl/cbg_div.sv
rtl/cbg_emit.sv
rtl/char_lcd_bar_graph_codes.sv
bench/cbg_checker.sv
bench/char_lcd_bar_graph_codes_tb.sv
